// ===== design/pud_pkg.sv =====
// Package for the percent URL decoder: item types, the job record passed
// from the front to the back, character codes and the hex helpers.
// No dependencies.
package pud_pkg;

  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  // One input item's worth of results: up to three bytes, in order b0, b1, b2
  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       last;
  } job_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
  endfunction

  // Valid only for hex characters; letters have bit 6 set
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    hex_value = c[6] ? (c[3:0] + 4'd9) : c[3:0];
  endfunction

endpackage

// ===== design/percent_url_decoder.sv =====
// Percent URL decoder, top level. Depends on pud_pkg, pud_front, pud_queue, pud_back.
// Path: each accepted character's job enters the queue, then the output register.
// Throughput: one character per cycle; the back emits one byte per cycle while
// the output is popped, so a character giving two or three bytes holds the back
// until its last byte is issued; full stalls the input at QUEUE_DEPTH jobs queued.
// Reset: synchronous active-low rst_n clears escape state, queue and output valid flag.
module percent_url_decoder #(
  parameter int unsigned QUEUE_DEPTH = pud_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  pud_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output pud_pkg::out_item_t out_item
);

  logic          accept, q_push, q_pop, q_valid;
  pud_pkg::job_t wr_job, rd_job;

  assign accept = push && !full;

  pud_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_item),
    .push   (q_push),
    .job    (wr_job)
  );

  pud_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_job (wr_job),
    .pop    (q_pop),
    .full   (full),
    .valid  (q_valid),
    .rd_job (rd_job)
  );

  pud_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_valid),
    .job       (rd_job),
    .job_pop   (q_pop),
    .pop       (pop && !empty),
    .empty     (empty),
    .item      (out_item)
  );

`ifndef SYNTHESIS
  a_full_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> q_valid) else $error("queue full with no head job");

  a_pop_when_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("job popped from empty queue");

  a_issue_shows: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> !empty) else $error("final byte of job not presented");

  a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && in_item.in_last) |-> (wr_job.cnt != 2'd0))
    else $error("end of string produced no result");
`endif

endmodule

// ===== design/pud_front.sv =====
// Front end: accepts characters, tracks the escape state and builds one job
// record per character, pushed only if it holds a byte. Depends on pud_pkg.
module pud_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  pud_pkg::in_item_t item,
  output logic             push,
  output pud_pkg::job_t    job
);

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_PCT  = 3'b010,
    PH_HOLD = 3'b100
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;

  always_comb begin
    logic [3:0][7:0] b;
    logic [1:0]      n;
    logic [7:0]      c;
    logic            pct;
    logic [7:0]      mapped;
    b         = '0;
    n         = 2'd0;
    c         = item.in_byte;
    pct       = (c == pud_pkg::CHAR_PERCENT);
    mapped    = (c == pud_pkg::CHAR_PLUS) ? pud_pkg::CHAR_SPACE : c;
    phase_nxt = PH_IDLE;
    held_nxt  = held_r;

    case (phase_r)
      PH_HOLD: begin
        if (pud_pkg::is_hex(c)) begin
          b[n] = {pud_pkg::hex_value(held_r), pud_pkg::hex_value(c)};
          n    = n + 2'd1;
        end else begin
          b[n] = pud_pkg::CHAR_PERCENT;
          n    = n + 2'd1;
          b[n] = held_r;
          n    = n + 2'd1;
          if (pct) begin
            phase_nxt = PH_PCT;
          end else begin
            b[n] = mapped;
            n    = n + 2'd1;
          end
        end
      end
      PH_PCT: begin
        if (pud_pkg::is_hex(c)) begin
          phase_nxt = PH_HOLD;
          held_nxt  = c;
        end else begin
          b[n] = pud_pkg::CHAR_PERCENT;
          n    = n + 2'd1;
          if (pct) begin
            phase_nxt = PH_PCT;
          end else begin
            b[n] = mapped;
            n    = n + 2'd1;
          end
        end
      end
      default: begin
        if (pct) begin
          phase_nxt = PH_PCT;
        end else begin
          b[n] = mapped;
          n    = n + 2'd1;
        end
      end
    endcase

    // end of string: flush whatever escape is still pending
    if (item.in_last) begin
      if (phase_nxt == PH_PCT) begin
        b[n] = pud_pkg::CHAR_PERCENT;
        n    = n + 2'd1;
      end else if (phase_nxt == PH_HOLD) begin
        b[n] = pud_pkg::CHAR_PERCENT;
        n    = n + 2'd1;
        b[n] = held_nxt;
        n    = n + 2'd1;
      end
      phase_nxt = PH_IDLE;
    end

    job.cnt  = n;
    job.b0   = b[0];
    job.b1   = b[1];
    job.b2   = b[2];
    job.last = item.in_last;
  end

  assign push = accept && (job.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= 8'h00;
    end else if (accept) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

// ===== design/pud_queue.sv =====
// Short job queue between front and back, flop storage with write and read
// pointers and an occupancy count. Depends on pud_pkg.
module pud_queue #(
  parameter int unsigned Depth = pud_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pud_pkg::job_t wr_job,
  input  logic          pop,
  output logic          full,
  output logic          valid,
  output pud_pkg::job_t rd_job
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  pud_pkg::job_t mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r;

  function automatic logic [PtrW-1:0] inc_ptr(input logic [PtrW-1:0] p);
    inc_ptr = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full   = (count_r == CntW'(Depth));
  assign valid  = (count_r != '0);
  assign rd_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= inc_ptr(wr_ptr_r);
      if (pop)  rd_ptr_r <= inc_ptr(rd_ptr_r);
      if (push && !pop) begin
        count_r <= count_r + CntW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CntW'(1);
      end
    end
  end

endmodule

// ===== design/pud_back.sv =====
// Back end: walks the bytes of the head job one per cycle into the output
// register while it is free or being popped. Depends on pud_pkg.
module pud_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  input  pud_pkg::job_t     job,
  output logic              job_pop,
  input  logic              pop,
  output logic              empty,
  output pud_pkg::out_item_t item
);

  logic [1:0]         idx_r, idx_nxt;
  logic               out_valid_r;
  pud_pkg::out_item_t out_r;
  logic               load, issue, final_byte;
  logic [7:0]         sel_byte;

  assign load       = !out_valid_r || pop;
  assign issue      = job_valid && load;
  assign final_byte = (idx_r == job.cnt - 2'd1);
  assign job_pop    = issue && final_byte;
  assign idx_nxt    = final_byte ? 2'd0 : idx_r + 2'd1;

  always_comb begin
    case (idx_r)
      2'd0:    sel_byte = job.b0;
      2'd1:    sel_byte = job.b1;
      default: sel_byte = job.b2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (issue) idx_r <= idx_nxt;
      if (load)  out_valid_r <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      out_r.out_byte <= sel_byte;
      out_r.out_last <= job.last && final_byte;
    end
  end

  assign empty = !out_valid_r;
  assign item  = out_r;

endmodule
